### rtl/bpc_pkg.sv
`default_nettype none
package bpc_pkg;

  localparam int RAW_W       = 24;
  localparam int CAL_W       = 16;
  localparam int TEMP_W      = 20;
  localparam int PRES_W      = 32;
  localparam int DT_W        = 26;
  localparam int MUL_W       = 43;
  localparam int SQ_W        = 52;
  localparam int TSQ_W       = 40;
  localparam int OFF_W       = 41;
  localparam int SENS_W      = 40;
  localparam int CORR_W      = 42;
  localparam int SENS_LO_W   = 20;
  localparam int PL_W        = RAW_W + SENS_LO_W;
  localparam int PH_W        = RAW_W + 1 + SENS_W - SENS_LO_W;
  localparam int PROD_W      = 64;
  localparam int DIFF_W      = 48;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int NUM_REGS    = 6;
  localparam int REG_IDX_W   = 3;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;

  localparam logic [RAW_W-1:0] RAW_ALL_ONES = '1;
  localparam logic [RAW_W-1:0] RAW_ZERO     = '0;

  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = -20'sd1500;

  localparam logic [REG_IDX_W-1:0] REG_C1 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_C2 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_C3 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_C4 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_C5 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_C6 = 3'd5;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_PRES_BAD = 2'd1,
    STAT_TEMP_BAD = 2'd2
  } status_e;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } bpc_cal_t;

  typedef struct packed {
    logic [RAW_W-1:0] d1;
    logic [RAW_W-1:0] d2;
    status_e          status;
  } bpc_item_t;

endpackage
`default_nettype wire

### rtl/bpc_front.sv
`default_nettype none
module bpc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  input  logic [bpc_pkg::IN_TDATA_W-1:0] s_data_i,
  output logic                          s_ready_o,
  output logic                          push_o,
  output bpc_pkg::bpc_item_t            item_o,
  input  logic                          q_full_i
);
  import bpc_pkg::*;

  logic      valid_q;
  bpc_item_t item_q;
  bpc_item_t item_d;
  logic      take;

  logic [RAW_W-1:0] d1;
  logic [RAW_W-1:0] d2;

  assign d1 = s_data_i[RAW_W-1:0];
  assign d2 = s_data_i[2*RAW_W-1:RAW_W];

  always_comb begin
    item_d.d1     = d1;
    item_d.d2     = d2;
    item_d.status = STAT_OK;
    if (d1 == RAW_ZERO || d1 == RAW_ALL_ONES) begin
      item_d.status = STAT_PRES_BAD;
    end else if (d2 == RAW_ZERO || d2 == RAW_ALL_ONES) begin
      item_d.status = STAT_TEMP_BAD;
    end
  end

  assign push_o    = valid_q && !q_full_i;
  assign s_ready_o = !valid_q || !q_full_i;
  assign take      = s_valid_i && s_ready_o;
  assign item_o    = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

### rtl/bpc_fifo.sv
`default_nettype none
module bpc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bpc_pkg::bpc_item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  output bpc_pkg::bpc_item_t item_o,
  input  logic               pop_i
);
  import bpc_pkg::*;

  bpc_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic [QPTR_W:0]   count_d;

  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count above depth");

  a_count_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != (QPTR_W+1)'(QDEPTH)) |-> (QPTR_W'(count_q) == QPTR_W'(wr_ptr_q - rd_ptr_q)))
    else $error("queue count disagrees with pointers");

endmodule
`default_nettype wire

### rtl/bpc_back.sv
`default_nettype none
module bpc_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bpc_pkg::bpc_cal_t                 cal_i,
  input  logic                              q_valid_i,
  input  bpc_pkg::bpc_item_t                q_item_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [bpc_pkg::TEMP_W-1:0] out_temp_o,
  output logic signed [bpc_pkg::PRES_W-1:0] out_pres_o,
  output bpc_pkg::status_e                  out_status_o
);
  import bpc_pkg::*;

  localparam int NSTG = 8;

  logic            en;
  logic [NSTG-1:0] vld_q;
  status_e         st_q [NSTG];
  logic [RAW_W-1:0] d1_q [6];

  // stage 1
  logic signed [DT_W-1:0] dt_q;
  // stage 2
  logic signed [MUL_W-1:0] p6, p4, p3;
  logic signed [SQ_W-1:0]  pdd;
  logic signed [MUL_W-1:0] p6_q, p4_q, p3_q;
  logic signed [SQ_W-1:0]  pdd_q;
  // stage 3
  logic signed [TEMP_W-1:0] temp3_q, t2_3_q;
  logic signed [OFF_W-1:0]  off3_q;
  logic signed [SENS_W-1:0] sens3_q;
  // stage 4
  logic signed [TEMP_W-1:0] a_dev, b_dev;
  logic signed [TSQ_W-1:0]  aa, bb;
  logic signed [TSQ_W-1:0]  aa_q, bb_q;
  logic                     warm_lt_q, cold_lt_q;
  logic signed [TEMP_W-1:0] temp4_q, t2_4_q;
  logic signed [OFF_W-1:0]  off4_q;
  logic signed [SENS_W-1:0] sens4_q;
  // stage 5
  logic signed [CORR_W-1:0] aa_x, bb_x, aa5, bb7, bb11, off2a, off2, sens2;
  logic signed [CORR_W-1:0] off2_q, sens2_q;
  logic signed [TEMP_W-1:0] temp5_q;
  logic signed [OFF_W-1:0]  off5_q;
  logic signed [SENS_W-1:0] sens5_q;
  // stage 6
  logic signed [OFF_W-1:0]  off6_q;
  logic signed [SENS_W-1:0] sens6_q;
  logic signed [TEMP_W-1:0] temp6_q;
  // stage 7
  logic [SENS_LO_W-1:0]               sens_lo;
  logic signed [SENS_W-SENS_LO_W-1:0] sens_hi;
  logic [PL_W-1:0]                    pl, pl_q;
  logic signed [PH_W-1:0]             ph, ph_q;
  logic signed [OFF_W-1:0]            off7_q;
  logic signed [TEMP_W-1:0]           temp7_q;
  // stage 8
  logic signed [PROD_W-1:0] prod_q;
  logic signed [OFF_W-1:0]  off8_q;
  logic signed [TEMP_W-1:0] temp8_q;
  // output
  logic signed [DIFF_W-1:0] diff;
  logic                     out_valid_q;
  logic signed [TEMP_W-1:0] out_temp_q;
  logic signed [PRES_W-1:0] out_pres_q;
  status_e                  out_status_q;

  assign en      = !out_valid_q || out_ready_i;
  assign q_pop_o = en && q_valid_i;

  assign p6  = dt_q * $signed({1'b0, cal_i.c6});
  assign p4  = dt_q * $signed({1'b0, cal_i.c4});
  assign p3  = dt_q * $signed({1'b0, cal_i.c3});
  assign pdd = dt_q * dt_q;

  assign a_dev = temp3_q - TEMP_REF;
  assign b_dev = temp3_q - TEMP_COLD;
  assign aa    = a_dev * a_dev;
  assign bb    = b_dev * b_dev;

  assign aa_x  = CORR_W'(aa_q);
  assign bb_x  = CORR_W'(bb_q);
  assign aa5   = (aa_x <<< 2) + aa_x;
  assign bb7   = (bb_x <<< 3) - bb_x;
  assign bb11  = (bb_x <<< 3) + (bb_x <<< 1) + bb_x;
  assign off2a = aa5 >>> 1;

  always_comb begin
    off2  = '0;
    sens2 = '0;
    if (warm_lt_q) begin
      off2  = off2a;
      sens2 = off2a >>> 1;
      if (cold_lt_q) begin
        off2  = off2a + bb7;
        sens2 = (off2a >>> 1) + (bb11 >>> 1);
      end
    end
  end

  assign sens_lo = sens6_q[SENS_LO_W-1:0];
  assign sens_hi = sens6_q[SENS_W-1:SENS_LO_W];
  assign pl      = d1_q[5] * sens_lo;
  assign ph      = $signed({1'b0, d1_q[5]}) * sens_hi;

  assign diff = DIFF_W'(prod_q >>> 21) - DIFF_W'(off8_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NSTG-2:0], q_valid_i};
      out_valid_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= q_item_i.status;
      for (int i = 1; i < NSTG; i++) begin
        st_q[i] <= st_q[i-1];
      end
      d1_q[0] <= q_item_i.d1;
      for (int i = 1; i < 6; i++) begin
        d1_q[i] <= d1_q[i-1];
      end

      dt_q <= $signed({2'b00, q_item_i.d2}) - $signed({2'b00, cal_i.c5, 8'd0});

      p6_q  <= p6;
      p4_q  <= p4;
      p3_q  <= p3;
      pdd_q <= pdd;

      temp3_q <= TEMP_W'(p6_q >>> 23) + TEMP_REF;
      off3_q  <= OFF_W'($signed({1'b0, cal_i.c2, 16'd0})) + OFF_W'(p4_q >>> 7);
      sens3_q <= SENS_W'($signed({1'b0, cal_i.c1, 15'd0})) + SENS_W'(p3_q >>> 8);
      t2_3_q  <= TEMP_W'(pdd_q >>> 31);

      aa_q      <= aa;
      bb_q      <= bb;
      warm_lt_q <= temp3_q < TEMP_REF;
      cold_lt_q <= temp3_q < TEMP_COLD;
      temp4_q   <= temp3_q;
      t2_4_q    <= t2_3_q;
      off4_q    <= off3_q;
      sens4_q   <= sens3_q;

      off2_q  <= off2;
      sens2_q <= sens2;
      temp5_q <= warm_lt_q ? (temp4_q - t2_4_q) : temp4_q;
      off5_q  <= off4_q;
      sens5_q <= sens4_q;

      off6_q  <= off5_q - OFF_W'(off2_q);
      sens6_q <= sens5_q - SENS_W'(sens2_q);
      temp6_q <= temp5_q;

      pl_q    <= pl;
      ph_q    <= ph;
      off7_q  <= off6_q;
      temp7_q <= temp6_q;

      prod_q  <= (PROD_W'(ph_q) <<< SENS_LO_W)
                 + $signed({{(PROD_W-PL_W){1'b0}}, pl_q});
      off8_q  <= off7_q;
      temp8_q <= temp7_q;

      out_status_q <= st_q[NSTG-1];
      if (st_q[NSTG-1] == STAT_OK) begin
        out_temp_q <= temp8_q;
        out_pres_q <= diff[15 +: PRES_W];
      end else begin
        out_temp_q <= '0;
        out_pres_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_temp_o   = out_temp_q;
  assign out_pres_o   = out_pres_q;
  assign out_status_o = out_status_q;

  a_bad_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != STAT_OK) |-> (out_temp_q == '0 && out_pres_q == '0))
    else $error("invalid result carries nonzero data");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  a_pop_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> vld_q[0])
    else $error("popped item lost at first stage");

endmodule
`default_nettype wire

### rtl/baro_pressure_temp_compensation_unit.sv
// Barometric pressure/temperature second-order compensation.
// Input stream: one transfer carries a raw pressure and raw temperature
// conversion pair (s_axis_*). Output stream: one result per input transfer,
// in order, with temperature in 0.01 C, pressure in Pa and a status code
// in tuser (0 ok, 1 raw pressure invalid, 2 raw temperature invalid; data
// is zero when invalid).
// Calibration words C1..C6 sit on the APB port at byte addresses 0x00..0x14;
// write them only while no transfer is in flight.
// Throughput: one transfer per cycle while m_axis_tready is high. An input
// transfer passes the input register, 4-entry queue, 8-stage arithmetic
// pipeline and output register in that order. The arithmetic pipeline is set by
// the 24x40 pressure product, split into two partial products.
// Reset clears the calibration words to zero and empties the queue and the
// pipeline. When m_axis_tready is low with a result held at the output, the
// pipeline holds; the queue and the input register keep accepting until both
// are full, then s_axis_tready drops.
`default_nettype none
module baro_pressure_temp_compensation_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [bpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [19:0] temperature_centi, [51:20] pressure_pa, [55:52] zero
  output logic [bpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [bpc_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpc_pkg::APB_AW-1:0]      paddr,
  input  logic [bpc_pkg::APB_DW-1:0]      pwdata,
  output logic [bpc_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import bpc_pkg::*;

  bpc_cal_t cal_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  logic      push;
  bpc_item_t front_item;
  logic      q_full;
  logic      q_valid;
  bpc_item_t q_item;
  logic      q_pop;

  logic signed [TEMP_W-1:0] res_temp;
  logic signed [PRES_W-1:0] res_pres;
  status_e                  res_status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (wr_en && (32'(reg_idx) < NUM_REGS)) begin
      case (reg_idx)
        REG_C1:  cal_q.c1 <= pwdata[CAL_W-1:0];
        REG_C2:  cal_q.c2 <= pwdata[CAL_W-1:0];
        REG_C3:  cal_q.c3 <= pwdata[CAL_W-1:0];
        REG_C4:  cal_q.c4 <= pwdata[CAL_W-1:0];
        REG_C5:  cal_q.c5 <= pwdata[CAL_W-1:0];
        REG_C6:  cal_q.c6 <= pwdata[CAL_W-1:0];
        default: cal_q    <= cal_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_C1:  prdata = APB_DW'(cal_q.c1);
      REG_C2:  prdata = APB_DW'(cal_q.c2);
      REG_C3:  prdata = APB_DW'(cal_q.c3);
      REG_C4:  prdata = APB_DW'(cal_q.c4);
      REG_C5:  prdata = APB_DW'(cal_q.c5);
      REG_C6:  prdata = APB_DW'(cal_q.c6);
      default: prdata = '0;
    endcase
  end

  bpc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_data_i  (s_axis_tdata),
    .s_ready_o (s_axis_tready),
    .push_o    (push),
    .item_o    (front_item),
    .q_full_i  (q_full)
  );

  bpc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  bpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cal_i        (cal_q),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_temp_o   (res_temp),
    .out_pres_o   (res_pres),
    .out_status_o (res_status)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-TEMP_W-PRES_W){1'b0}}, res_pres, res_temp};
  assign m_axis_tuser = OUT_TUSER_W'(res_status);

endmodule
`default_nettype wire
